// File: rtl/lpm_pkg.sv
// Shared types and constants of the layered page mapper.
`default_nettype none
package lpm_pkg;

  localparam int CPU_AW       = 16;
  localparam int HOST_PW      = 22;
  localparam int HOST_AW      = 32;
  localparam int CNT_W        = 7;
  localparam int ENTRY_W      = 2 * HOST_PW + 1;

  localparam int N_LAYERS_DEF   = 4;
  localparam int N_PAGES_DEF    = 64;
  localparam int PAGE_SHIFT_DEF = 10;

  typedef enum logic [1:0] {
    OP_MAP     = 2'd0,
    OP_CLR_ONE = 2'd1,
    OP_CLR_ALL = 2'd2,
    OP_LOOKUP  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic load;
    logic step;
    logic look;
    logic emit;
  } lpm_cmd_t;

  typedef struct packed {
    logic map_go;
    logic is_look;
    logic last;
  } lpm_stat_t;

endpackage
`default_nettype wire

// File: rtl/lpm_if.sv
// Valid/ready channel interfaces for command words and result words.
`default_nettype none
interface lpm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  layer_sel;
  logic [15:0] cpu_addr;
  logic [6:0]  page_count;
  logic [21:0] read_base;
  logic [21:0] write_base;
  logic        has_write;

  modport source (output valid, opcode, layer_sel, cpu_addr, page_count, read_base,
                  write_base, has_write, input ready);
  modport sink   (input valid, opcode, layer_sel, cpu_addr, page_count, read_base,
                  write_base, has_write, output ready);
endinterface

interface lpm_out_if;
  logic        valid;
  logic        ready;
  logic        is_lookup;
  logic        mapped;
  logic [1:0]  layer_found;
  logic [31:0] read_addr;
  logic        write_ok;
  logic [31:0] write_addr;

  modport source (output valid, is_lookup, mapped, layer_found, read_addr, write_ok,
                  write_addr, input ready);
  modport sink   (input valid, is_lookup, mapped, layer_found, read_addr, write_ok,
                  write_addr, output ready);
endinterface
`default_nettype wire

// File: rtl/lpm_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/lpm_ctrl.sv
// Sequencing state machine of the layered page mapper.
`default_nettype none
module lpm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire lpm_pkg::lpm_stat_t stat,
  output lpm_pkg::lpm_cmd_t       cmd
);
  import lpm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAP  = 4'b0010,
    ST_LOOK = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          priority if (stat.map_go) begin
            state_nxt = ST_MAP;
          end else if (stat.is_look) begin
            state_nxt = ST_LOOK;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_MAP: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/lpm_datapath.sv
// Datapath: per-layer valid bits, entry RAM, page walk counters and result register.
`default_nettype none
module lpm_datapath #(
  parameter int N_LAYERS   = lpm_pkg::N_LAYERS_DEF,
  parameter int N_PAGES    = lpm_pkg::N_PAGES_DEF,
  parameter int PAGE_SHIFT = lpm_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lpm_pkg::lpm_cmd_t cmd,
  output lpm_pkg::lpm_stat_t     stat,
  input  wire logic [1:0]        opcode,
  input  wire logic [1:0]        layer_sel,
  input  wire logic [15:0]       cpu_addr,
  input  wire logic [6:0]        page_count,
  input  wire logic [21:0]       read_base,
  input  wire logic [21:0]       write_base,
  input  wire logic              has_write,
  output logic                   is_lookup,
  output logic                   mapped,
  output logic [1:0]             layer_found,
  output logic [31:0]            read_addr,
  output logic                   write_ok,
  output logic [31:0]            write_addr
);
  import lpm_pkg::*;

  localparam int LW    = (N_LAYERS > 1) ? $clog2(N_LAYERS) : 1;
  localparam int PW    = $clog2(N_PAGES);
  localparam int CW    = $clog2(N_PAGES + 1);
  localparam int QW    = CPU_AW - PAGE_SHIFT;
  localparam int QN    = 1 << QW;
  localparam int AW    = LW + PW;
  localparam int DEPTH = N_LAYERS << PW;

  opcode_t                op_in;
  logic                   lsel_ok;
  logic [LW-1:0]          lsel_in;

  logic                   look_r;
  logic [LW-1:0]          lsel_r;
  logic [QW-1:0]          q_r;
  logic [PAGE_SHIFT-1:0]  off_r;
  logic [CW-1:0]          rem_r;
  logic [HOST_PW-1:0]     rd_r;
  logic [HOST_PW-1:0]     wr_r;
  logic                   hasw_r;
  logic                   hit_r;
  logic [LW-1:0]          win_r;
  logic [N_PAGES-1:0]     vld_r   [N_LAYERS];
  logic [N_PAGES-1:0]     vld_nxt [N_LAYERS];

  logic [PW-1:0]          pg_tab [QN];
  logic [PW-1:0]          pg_cur;
  logic                   hit;
  logic [LW-1:0]          win;

  logic                   ram_we;
  logic                   ram_re;
  logic [AW-1:0]          ram_addr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [HOST_PW-1:0]     rd_q;
  logic [HOST_PW-1:0]     wr_q;
  logic                   wrv_q;
  logic [63:0]            rd_full;
  logic [63:0]            wr_full;

  // CPU page number to table page, reduced modulo the page count.
  for (genvar g = 0; g < QN; g++) begin : g_pgtab
    assign pg_tab[g] = PW'(g % N_PAGES);
  end

  assign op_in   = opcode_t'(opcode);
  assign lsel_ok = 32'(layer_sel) < 32'(N_LAYERS);
  assign lsel_in = LW'(layer_sel);
  assign pg_cur  = pg_tab[q_r];

  assign stat.map_go  = (op_in == OP_MAP) && lsel_ok && (page_count != '0);
  assign stat.is_look = (op_in == OP_LOOKUP);
  assign stat.last    = (rem_r == CW'(1));

  // Lowest-numbered layer holding a valid entry for the page wins.
  always_comb begin
    hit = 1'b0;
    win = '0;
    for (int l = N_LAYERS - 1; l >= 0; l--) begin
      if (vld_r[l][pg_cur]) begin
        hit = 1'b1;
        win = LW'(l);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < N_LAYERS; l++) begin
      vld_nxt[l] = vld_r[l];
    end
    if (cmd.load && (op_in == OP_CLR_ALL)) begin
      for (int l = 0; l < N_LAYERS; l++) begin
        vld_nxt[l] = '0;
      end
    end else if (cmd.load && (op_in == OP_CLR_ONE) && lsel_ok) begin
      vld_nxt[lsel_in] = '0;
    end else if (cmd.step) begin
      vld_nxt[lsel_r][pg_cur] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < N_LAYERS; l++) begin
        vld_r[l] <= '0;
      end
    end else begin
      for (int l = 0; l < N_LAYERS; l++) begin
        vld_r[l] <= vld_nxt[l];
      end
    end
  end

  assign ram_we    = cmd.step;
  assign ram_re    = cmd.look;
  assign ram_addr  = cmd.step ? {lsel_r, pg_cur} : {win, pg_cur};
  assign ram_wdata = {rd_r, hasw_r, hasw_r ? wr_r : HOST_PW'(0)};

  lpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_q    = ram_rdata[ENTRY_W-1 -: HOST_PW];
  assign wrv_q   = ram_rdata[HOST_PW];
  assign wr_q    = ram_rdata[HOST_PW-1:0];
  assign rd_full = 64'({rd_q, off_r});
  assign wr_full = 64'({wr_q, off_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      look_r <= (op_in == OP_LOOKUP);
      lsel_r <= lsel_in;
      q_r    <= cpu_addr[CPU_AW-1:PAGE_SHIFT];
      off_r  <= cpu_addr[PAGE_SHIFT-1:0];
      rd_r   <= read_base;
      wr_r   <= write_base;
      hasw_r <= has_write;
      if (32'(page_count) > 32'(N_PAGES)) begin
        rem_r <= CW'(N_PAGES);
      end else begin
        rem_r <= CW'(page_count);
      end
    end else if (cmd.step) begin
      q_r   <= q_r + QW'(1);
      rd_r  <= rd_r + HOST_PW'(1);
      wr_r  <= wr_r + HOST_PW'(1);
      rem_r <= rem_r - CW'(1);
    end
    if (cmd.look) begin
      hit_r <= hit;
      win_r <= win;
    end
    if (cmd.emit) begin
      is_lookup   <= look_r;
      mapped      <= look_r && hit_r;
      layer_found <= (look_r && hit_r) ? 2'(win_r) : 2'd0;
      read_addr   <= (look_r && hit_r) ? rd_full[31:0] : 32'd0;
      write_ok    <= look_r && hit_r && wrv_q;
      write_addr  <= (look_r && hit_r && wrv_q) ? wr_full[31:0] : 32'd0;
    end
  end
endmodule
`default_nettype wire

// File: rtl/layered_page_mapper_top.sv
// A map of N pages (N saturated to the page count) walks ST_MAP, writing one page per
// cycle through the single entry RAM port, then goes to ST_RESP; clears, and maps with
// no pages or a bad layer, go straight to ST_RESP; lookups pass through ST_LOOK first.
// ST_RESP loads the result once the output is free; only ST_IDLE takes a command word.
// Reset (synchronous, active low) clears every per-layer valid bit at once, so all pages
// read as unmapped immediately; there is no clearing pass and the entry RAM is not reset.
`default_nettype none
module layered_page_mapper_top #(
  parameter int N_LAYERS   = lpm_pkg::N_LAYERS_DEF,
  parameter int N_PAGES    = lpm_pkg::N_PAGES_DEF,
  parameter int PAGE_SHIFT = lpm_pkg::PAGE_SHIFT_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  lpm_in_if.sink   in_ch,
  lpm_out_if.source out_ch
);
  import lpm_pkg::*;

  // The controller owns both handshakes; the datapath owns all payload and storage.
  // Visible entries are not stored: a lookup resolves priority from the valid bits and
  // then reads the winning layer's entry from the RAM, which gives the same answer.
  lpm_cmd_t  cmd;
  lpm_stat_t stat;
  logic      in_ready;
  logic      out_valid;

  lpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lpm_datapath #(
    .N_LAYERS   (N_LAYERS),
    .N_PAGES    (N_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (in_ch.opcode),
    .layer_sel   (in_ch.layer_sel),
    .cpu_addr    (in_ch.cpu_addr),
    .page_count  (in_ch.page_count),
    .read_base   (in_ch.read_base),
    .write_base  (in_ch.write_base),
    .has_write   (in_ch.has_write),
    .is_lookup   (out_ch.is_lookup),
    .mapped      (out_ch.mapped),
    .layer_found (out_ch.layer_found),
    .read_addr   (out_ch.read_addr),
    .write_ok    (out_ch.write_ok),
    .write_addr  (out_ch.write_addr)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

`ifndef SYNTH
  // One command word at a time: input is not ready again straight after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("input accepted while a command word is in progress");

  // Loading the result register always presents a result word next cycle.
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("result word loaded but not presented");

  // Acknowledge words carry an all-zero payload.
  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ch.is_lookup) |->
      (!out_ch.mapped && !out_ch.write_ok && out_ch.read_addr == 32'd0 &&
       out_ch.write_addr == 32'd0 && out_ch.layer_found == 2'd0))
    else $error("acknowledge word with nonzero payload");
`endif
endmodule
`default_nettype wire
